@@ rtl/ssrsn_pkg.sv @@
// ----------------------------------------------------------------------------
// ssrsn_pkg: shared constants, types and helpers
// Sizes of the stores, field widths and the command that moves from the
// front end to the back end through the queue.
// ----------------------------------------------------------------------------
package ssrsn_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_NONZEROS = 4096;

  localparam int ROW_W  = $clog2(MAX_ROWS);          // row index
  localparam int ROWC_W = $clog2(MAX_ROWS + 1);      // row count
  localparam int ADDR_W = $clog2(MAX_NONZEROS);      // entry address
  localparam int CNT_W  = $clog2(MAX_NONZEROS + 1);  // entry count

  localparam int VAL_W  = 32;
  localparam int COL_W  = 10;
  localparam int ROOT_W = 32;
  localparam int FRAC_W = 24;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [ROOT_W-1:0] ROOT_SAT = {ROOT_W{1'b1}};

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [COL_W-1:0]  column;
    logic              do_root;
    logic              do_store;
    logic              do_close;
    logic              do_norm;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] store_addr;
    logic [CNT_W-1:0]  close_end;
    logic [ROWC_W-1:0] rows;
  } cmd_t;

  function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
    magnitude = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

endpackage

@@ rtl/ssrsn_front.sv @@
// ----------------------------------------------------------------------------
// ssrsn_front: item intake and classification
// Tracks rows and entries of the matrix being loaded and turns each item
// into a command for the back end.
// ----------------------------------------------------------------------------
module ssrsn_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [ssrsn_pkg::VAL_W-1:0]     entry_value,
  input  logic [ssrsn_pkg::COL_W-1:0]     column_index,
  input  logic                            row_last,
  input  logic                            matrix_last,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output ssrsn_pkg::cmd_t                 cmd
);

  logic [ssrsn_pkg::ROWC_W-1:0] row_count;
  logic [ssrsn_pkg::CNT_W-1:0]  entry_count;
  logic                         in_row;
  logic                         active;
  logic                         accept;
  logic [ssrsn_pkg::CNT_W-1:0]  entry_count_next;

  assign item_ready = cmd_ready;
  assign cmd_valid  = item_valid;
  assign accept     = item_valid && cmd_ready;

  always_comb begin
    active           = row_count < ssrsn_pkg::ROWC_W'(ssrsn_pkg::MAX_ROWS);
    cmd.value        = entry_value;
    cmd.column       = column_index;
    cmd.do_root      = active && !in_row;
    cmd.do_store     = active && (entry_count < ssrsn_pkg::CNT_W'(ssrsn_pkg::MAX_NONZEROS));
    cmd.do_close     = active && (row_last || matrix_last);
    cmd.do_norm      = matrix_last;
    cmd.row          = row_count[ssrsn_pkg::ROW_W-1:0];
    cmd.store_addr   = entry_count[ssrsn_pkg::ADDR_W-1:0];
    entry_count_next = entry_count + ssrsn_pkg::CNT_W'(cmd.do_store);
    cmd.close_end    = entry_count_next;
    cmd.rows         = row_count + ssrsn_pkg::ROWC_W'(cmd.do_close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      entry_count <= '0;
      in_row      <= 1'b0;
    end else if (accept) begin
      if (matrix_last) begin
        row_count   <= '0;
        entry_count <= '0;
        in_row      <= 1'b0;
      end else begin
        row_count   <= cmd.rows;
        entry_count <= entry_count_next;
        if (active) begin
          in_row <= !cmd.do_close;
        end
      end
    end
  end

endmodule

@@ rtl/ssrsn_queue.sv @@
// ----------------------------------------------------------------------------
// ssrsn_queue: command queue between front and back end
// Small first-in first-out store so that intake and work stall apart.
// ----------------------------------------------------------------------------
module ssrsn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  ssrsn_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop,
  output ssrsn_pkg::cmd_t pop_cmd
);

  ssrsn_pkg::cmd_t                slots [ssrsn_pkg::Q_DEPTH];
  logic [ssrsn_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [ssrsn_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [ssrsn_pkg::Q_CNT_W-1:0]  count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = count != ssrsn_pkg::Q_CNT_W'(ssrsn_pkg::Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + ssrsn_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + ssrsn_pkg::Q_PTR_W'(1);
      end
      count <= count + ssrsn_pkg::Q_CNT_W'(do_push) - ssrsn_pkg::Q_CNT_W'(do_pop);
    end
  end

endmodule

@@ rtl/ssrsn_root.sv @@
// ----------------------------------------------------------------------------
// ssrsn_root: inverse square root unit
// Forms floor(2^64 / m) one quotient bit a cycle, then its integer square
// root one result bit a cycle. Needs m of at least 2.
// ----------------------------------------------------------------------------
module ssrsn_root (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ssrsn_pkg::VAL_W-1:0]  m,
  output logic                         done,
  output logic [ssrsn_pkg::ROOT_W-1:0] root
);

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_DIV  = 2'd1;
  localparam logic [1:0] RS_SQRT = 2'd2;

  localparam int QW = 2 * ssrsn_pkg::ROOT_W;

  logic [1:0]                   state;
  logic [ssrsn_pkg::VAL_W-1:0]  divisor;
  logic [ssrsn_pkg::VAL_W:0]    rem;
  logic [QW-1:0]                quo;
  logic [$clog2(QW)-1:0]        step;
  logic [ssrsn_pkg::VAL_W:0]    rem_sh;
  logic                         q_bit;
  logic [ssrsn_pkg::ROOT_W-1:0] trial;
  logic [QW-1:0]                trial_sq;

  always_comb begin
    rem_sh   = {rem[ssrsn_pkg::VAL_W-1:0], 1'b0};
    q_bit    = rem_sh >= {1'b0, divisor};
    trial    = root | (ssrsn_pkg::ROOT_W'(1) << step[$clog2(ssrsn_pkg::ROOT_W)-1:0]);
    trial_sq = QW'(trial) * QW'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        RS_IDLE: begin
          done <= 1'b0;
          if (start) begin
            divisor <= m;
            rem     <= (ssrsn_pkg::VAL_W + 1)'(1);
            quo     <= '0;
            step    <= $clog2(QW)'(QW - 1);
            state   <= RS_DIV;
          end
        end
        RS_DIV: begin
          done <= 1'b0;
          rem  <= q_bit ? (rem_sh - {1'b0, divisor}) : rem_sh;
          quo  <= {quo[QW-2:0], q_bit};
          if (step == '0) begin
            root  <= '0;
            step  <= $clog2(QW)'(ssrsn_pkg::ROOT_W - 1);
            state <= RS_SQRT;
          end else begin
            step <= step - $clog2(QW)'(1);
          end
        end
        RS_SQRT: begin
          if (trial_sq <= quo) begin
            root <= trial;
          end
          step <= step - $clog2(QW)'(1);
          done <= (step == '0);
          if (step == '0) begin
            state <= RS_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= RS_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/ssrsn_back.sv @@
// ----------------------------------------------------------------------------
// ssrsn_back: storage and norm pass
// Carries out queued commands: computes row roots, writes the stores and,
// at the end of a matrix, sweeps every row to find the largest scaled sum.
// ----------------------------------------------------------------------------
module ssrsn_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  ssrsn_pkg::cmd_t              cmd,
  output logic                         cmd_pop,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [ssrsn_pkg::VAL_W-1:0]  scaled_norm,
  output logic                         zero_diagonal,
  output logic                         saturated
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ROOT_WAIT = 4'd1;
  localparam logic [3:0] S_WRITE     = 4'd2;
  localparam logic [3:0] S_ROW       = 4'd3;
  localparam logic [3:0] S_ROW_DATA  = 4'd4;
  localparam logic [3:0] S_ENT       = 4'd5;
  localparam logic [3:0] S_ENT_DATA  = 4'd6;
  localparam logic [3:0] S_RJ        = 4'd7;
  localparam logic [3:0] S_MUL       = 4'd8;
  localparam logic [3:0] S_ACC       = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  localparam int RW  = ssrsn_pkg::ROOT_W;
  localparam int FW  = ssrsn_pkg::FRAC_W;
  localparam int T1W = ssrsn_pkg::VAL_W + RW - FW;
  localparam int HIW = T1W - FW;
  localparam int SW  = ssrsn_pkg::VAL_W + 1;
  localparam int AW  = HIW + RW + 2;

  logic [3:0] state;

  logic [ssrsn_pkg::VAL_W-1:0]  value_mem  [ssrsn_pkg::MAX_NONZEROS];
  logic [ssrsn_pkg::COL_W-1:0]  column_mem [ssrsn_pkg::MAX_NONZEROS];
  logic [ssrsn_pkg::CNT_W-1:0]  end_mem    [ssrsn_pkg::MAX_ROWS];
  logic [RW-1:0]                root_mem   [ssrsn_pkg::MAX_ROWS];

  logic [ssrsn_pkg::VAL_W-1:0]  value_rd;
  logic [ssrsn_pkg::COL_W-1:0]  column_rd;
  logic [ssrsn_pkg::CNT_W-1:0]  end_rd;
  logic [RW-1:0]                root_rd;

  logic [ssrsn_pkg::VAL_W-1:0]  cmd_mag;
  logic                         root_start;
  logic                         root_done;
  logic [RW-1:0]                root_res;
  logic [RW-1:0]                root_val;

  logic [ssrsn_pkg::ROWC_W-1:0] row_i;
  logic [ssrsn_pkg::CNT_W-1:0]  k;
  logic [ssrsn_pkg::CNT_W-1:0]  row_end;
  logic [RW-1:0]                ri;
  logic [ssrsn_pkg::VAL_W-1:0]  mag;
  logic [T1W-1:0]               t1;
  logic [HIW+RW-1:0]            p_hi;
  logic [FW+RW-1:0]             p_lo;
  logic [SW-1:0]                sum;
  logic [ssrsn_pkg::VAL_W-1:0]  run_max;
  logic                         zflag;
  logic                         sflag;

  logic                         ent_rd_en;
  logic                         root_rd_en;
  logic [ssrsn_pkg::ROW_W-1:0]  root_rd_addr;
  logic                         col_ok;
  logic [AW-1:0]                acc;
  logic [ssrsn_pkg::VAL_W-1:0]  row_sum;
  logic                         out_free;
  logic [2*ssrsn_pkg::VAL_W-1:0] prod1;

  always_comb begin
    cmd_mag      = ssrsn_pkg::magnitude(cmd.value);
    root_start   = (state == S_IDLE) && cmd_valid && cmd.do_root
                   && (cmd_mag > ssrsn_pkg::VAL_W'(1));
    ent_rd_en    = (state == S_ENT) && (k < row_end);
    col_ok       = {1'b0, column_rd} < ssrsn_pkg::ROWC_W'(cmd.rows);
    root_rd_en   = (state == S_ROW) || ((state == S_ENT_DATA) && col_ok);
    root_rd_addr = (state == S_ROW) ? row_i[ssrsn_pkg::ROW_W-1:0]
                                    : ssrsn_pkg::ROW_W'(column_rd);
    prod1        = (2*ssrsn_pkg::VAL_W)'(mag) * (2*ssrsn_pkg::VAL_W)'(ri);
    acc          = AW'(sum) + AW'(p_hi) + AW'(p_lo[FW+RW-1:FW]);
    row_sum      = sum[SW-1] ? {ssrsn_pkg::VAL_W{1'b1}} : sum[ssrsn_pkg::VAL_W-1:0];
    out_free     = !result_valid || result_ready;
    cmd_pop      = ((state == S_WRITE) && !cmd.do_norm) || ((state == S_OUT) && out_free);
  end

  ssrsn_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .m     (cmd_mag),
    .done  (root_done),
    .root  (root_res)
  );

  // stores
  always_ff @(posedge clk) begin
    if ((state == S_WRITE) && cmd.do_store) begin
      value_mem[cmd.store_addr]  <= cmd.value;
      column_mem[cmd.store_addr] <= cmd.column;
    end
    if ((state == S_WRITE) && cmd.do_close) begin
      end_mem[cmd.row] <= cmd.close_end;
    end
    if ((state == S_WRITE) && cmd.do_root) begin
      root_mem[cmd.row] <= root_val;
    end
    if (ent_rd_en) begin
      value_rd  <= value_mem[k[ssrsn_pkg::ADDR_W-1:0]];
      column_rd <= column_mem[k[ssrsn_pkg::ADDR_W-1:0]];
    end
    if (state == S_ROW) begin
      end_rd <= end_mem[row_i[ssrsn_pkg::ROW_W-1:0]];
    end
    if (root_rd_en) begin
      root_rd <= root_mem[root_rd_addr];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:      root_val <= ssrsn_pkg::ROOT_SAT;
      S_ROOT_WAIT: if (root_done) root_val <= root_res;
      S_ROW_DATA: begin
        row_end <= end_rd;
        ri      <= root_rd;
        sum     <= '0;
      end
      S_ENT_DATA:  mag <= ssrsn_pkg::magnitude(value_rd);
      S_RJ:        t1 <= prod1[FW +: T1W];
      S_MUL: begin
        p_hi <= (HIW+RW)'(t1[T1W-1:FW]) * (HIW+RW)'(root_rd);
        p_lo <= (FW+RW)'(t1[FW-1:0]) * (FW+RW)'(root_rd);
      end
      S_ACC: begin
        // clamp one past the output range, flag at the end of the row
        sum <= (acc > AW'({ssrsn_pkg::VAL_W{1'b1}})) ? {1'b1, {ssrsn_pkg::VAL_W{1'b0}}}
                                                     : SW'(acc);
      end
      default: ;
    endcase
  end

  // result valid: raise on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_i        <= '0;
      k            <= '0;
      run_max      <= '0;
      zflag        <= 1'b0;
      sflag        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= root_start ? S_ROOT_WAIT : S_WRITE;
          end
        end
        S_ROOT_WAIT: begin
          if (root_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (cmd.do_root && (cmd_mag == '0)) begin
            zflag <= 1'b1;
          end
          row_i <= '0;
          k     <= '0;
          if (!cmd.do_norm) begin
            state <= S_IDLE;
          end else if (cmd.rows == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_ROW;
          end
        end
        S_ROW:      state <= S_ROW_DATA;
        S_ROW_DATA: state <= S_ENT;
        S_ENT: begin
          if (k < row_end) begin
            state <= S_ENT_DATA;
          end else begin
            if (sum[SW-1]) begin
              sflag <= 1'b1;
            end
            if (row_sum > run_max) begin
              run_max <= row_sum;
            end
            row_i <= row_i + ssrsn_pkg::ROWC_W'(1);
            state <= (row_i + ssrsn_pkg::ROWC_W'(1) == cmd.rows) ? S_OUT : S_ROW;
          end
        end
        S_ENT_DATA: begin
          if (col_ok) begin
            state <= S_RJ;
          end else begin
            k     <= k + ssrsn_pkg::CNT_W'(1);
            state <= S_ENT;
          end
        end
        S_RJ:  state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          k     <= k + ssrsn_pkg::CNT_W'(1);
          state <= S_ENT;
        end
        S_OUT: begin
          if (out_free) begin
            scaled_norm   <= run_max;
            zero_diagonal <= zflag;
            saturated     <= sflag;
            run_max       <= '0;
            zflag         <= 1'b0;
            sflag         <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_root_done_waited: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (state == S_ROOT_WAIT))
    else $error("root unit finished with nobody waiting");

  a_sum_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENT) && sum[SW-1] |-> (sum[ssrsn_pkg::VAL_W-1:0] == '0))
    else $error("row sum passed its clamp value");

  a_entry_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENT_DATA) |-> (k < row_end))
    else $error("entry read beyond the end of its row");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && !out_free |=> result_valid && (state == S_OUT))
    else $error("result dropped while the receiver stalls");

endmodule

@@ rtl/sparse_scaled_row_sum_norm.sv @@
// ----------------------------------------------------------------------------
// sparse_scaled_row_sum_norm: scaled infinity norm of a sparse matrix
// Loads a square matrix in compressed-row order and returns the largest row
// sum of |a_ij| / sqrt(|d_i| |d_j|), in unsigned Q16.16.
// ----------------------------------------------------------------------------
// Use:
//   Input channel item_valid/item_ready carries one nonzero per item:
//   entry_value (signed Q16.16), column_index, row_last, matrix_last. The
//   first item of every row is that row's diagonal entry.
//   Result channel result_valid/result_ready carries one result per matrix,
//   on the item marked matrix_last: scaled_norm, zero_diagonal, saturated.
// Throughput and flow:
//   The front end takes an item a cycle while the four-entry command queue
//   has room. The back end writes a plain entry to the stores directly; on
//   the first entry of a row with a diagonal magnitude above 1 it first
//   waits for the shared root unit (64 divide steps plus 32 root steps).
//   After matrix_last the norm pass walks the stores: per row a row read,
//   then per entry an entry read, a root read, two multiply stages and an
//   accumulate (only the first two for a column outside the matrix).
// Reset: rst (synchronous) empties the queue and clears the row and entry
//   counters, the running maximum and the flags; the stores need no clear.
// Stall: a result waits in the output register; the back end keeps
//   working through queued items until the next matrix end, then holds.
// ----------------------------------------------------------------------------
module sparse_scaled_row_sum_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [ssrsn_pkg::VAL_W-1:0]  entry_value,
  input  logic [ssrsn_pkg::COL_W-1:0]  column_index,
  input  logic                         row_last,
  input  logic                         matrix_last,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [ssrsn_pkg::VAL_W-1:0]  scaled_norm,
  output logic                         zero_diagonal,
  output logic                         saturated
);

  // front end to queue
  ssrsn_pkg::cmd_t front_cmd;
  logic            front_valid;
  logic            front_ready;

  // queue to back end
  ssrsn_pkg::cmd_t back_cmd;
  logic            back_valid;
  logic            back_pop;

  // classify items: root needed, store slot, row close, matrix end
  ssrsn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .entry_value  (entry_value),
    .column_index (column_index),
    .row_last     (row_last),
    .matrix_last  (matrix_last),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready),
    .cmd          (front_cmd)
  );

  // hold commands while the back end is busy with roots or the norm pass
  ssrsn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop        (back_pop),
    .pop_cmd    (back_cmd)
  );

  // advance commands, sweep the matrix, present the result
  ssrsn_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (back_valid),
    .cmd           (back_cmd),
    .cmd_pop       (back_pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .scaled_norm   (scaled_norm),
    .zero_diagonal (zero_diagonal),
    .saturated     (saturated)
  );

endmodule

@@ bench/sparse_scaled_row_sum_norm_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_scaled_row_sum_norm_chk: result checker for the scaled norm block
// Watches both channels, keeps its own copy of the matrix loaded so far and
// predicts the norm on every matrix end, then compares each result with it.
// ----------------------------------------------------------------------------
module sparse_scaled_row_sum_norm_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [31:0] entry_value,
  input  logic [9:0]  column_index,
  input  logic        row_last,
  input  logic        matrix_last,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [31:0] scaled_norm,
  input  logic        zero_diagonal,
  input  logic        saturated,
  output int          fail_count,
  output int          pending_norms,
  output int          norms_seen
);

  typedef struct packed {
    logic [31:0] norm;
    logic        zdiag;
    logic        sat;
  } norm_result_t;

  logic [31:0] vals [ssrsn_pkg::MAX_NONZEROS];
  logic [9:0]  cols [ssrsn_pkg::MAX_NONZEROS];
  int          starts [ssrsn_pkg::MAX_ROWS + 1];
  logic [31:0] roots [ssrsn_pkg::MAX_ROWS];
  int          n_entries, n_rows;
  bit          open_row, zd_seen;
  norm_result_t norm_q[$];

  function automatic logic [31:0] abs_q16(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  // floor(2^32 / sqrt(m)), saturated for m <= 1
  function automatic logic [31:0] recip_root(input logic [31:0] m);
    logic [63:0] lim, r, t;
    if (m <= 1) return 32'hFFFF_FFFF;
    lim = 64'hFFFF_FFFF_FFFF_FFFF / m;
    if (64'hFFFF_FFFF_FFFF_FFFF % m == m - 1) lim++;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= lim) r = t;
    end
    return r[31:0];
  endfunction

  function automatic norm_result_t row_sum_norm();
    norm_result_t res;
    logic [63:0] sum, t1, term, ri, rj;
    res = '0;
    res.zdiag = zd_seen;
    for (int i = 0; i < n_rows; i++) begin
      sum = 0;
      ri = roots[i];
      for (int k = starts[i]; k < starts[i+1] && k < ssrsn_pkg::MAX_NONZEROS; k++) begin
        if (cols[k] >= n_rows) continue;
        rj = roots[cols[k]];
        t1 = (64'(abs_q16(vals[k])) * ri) >> 24;
        term = (t1 >> 24) * rj + (((t1 & 64'hFF_FFFF) * rj) >> 24);
        sum += term;
        if (sum > 64'hFFFF_FFFF) sum = 64'h1_0000_0000;
      end
      if (sum > 64'hFFFF_FFFF) begin
        res.sat = 1'b1;
        sum = 64'hFFFF_FFFF;
      end
      if (sum[31:0] > res.norm) res.norm = sum[31:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    norm_result_t want;
    if (rst) begin
      n_entries = 0; n_rows = 0; open_row = 0; zd_seen = 0;
      fail_count <= 0; norms_seen <= 0;
      norm_q.delete();
      starts[0] = 0;
    end else begin
      if (item_valid && item_ready) begin
        // blocking updates: the whole item is folded in before prediction
        if (n_rows < ssrsn_pkg::MAX_ROWS) begin
          if (!open_row) begin
            roots[n_rows] = recip_root(abs_q16(entry_value));
            if (entry_value == 0) zd_seen = 1;
            open_row = 1;
          end
          if (n_entries < ssrsn_pkg::MAX_NONZEROS) begin
            vals[n_entries] = entry_value;
            cols[n_entries] = column_index;
            n_entries = n_entries + 1;
          end
          if (row_last || matrix_last) begin
            n_rows = n_rows + 1;
            starts[n_rows] = n_entries;
            open_row = 0;
          end
        end
        if (matrix_last) begin
          norm_q.push_back(row_sum_norm());
          n_entries = 0; n_rows = 0; open_row = 0; zd_seen = 0;
        end
      end
      if (result_valid && result_ready) begin
        norms_seen <= norms_seen + 1;
        if (norm_q.size() == 0) begin
          $display("%0t: unexpected result norm=%h", $time, scaled_norm);
          fail_count <= fail_count + 1;
        end else begin
          want = norm_q.pop_front();
          if (want !== {scaled_norm, zero_diagonal, saturated}) begin
            $display("%0t: mismatch expected norm=%h zd=%b sat=%b actual norm=%h zd=%b sat=%b",
                     $time, want.norm, want.zdiag, want.sat,
                     scaled_norm, zero_diagonal, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_norms = norm_q.size();
endmodule

@@ bench/sparse_scaled_row_sum_norm_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_scaled_row_sum_norm_tb: top of the scaled norm bench
// Streams directed and random sparse matrices with bursty input and a
// stalling result side; the checker predicts and compares every norm.
// ----------------------------------------------------------------------------
module sparse_scaled_row_sum_norm_tb;
  logic        clk, rst;
  logic        item_valid, item_ready;
  logic [31:0] entry_value;
  logic [9:0]  column_index;
  logic        row_last, matrix_last;
  logic        result_valid, result_ready;
  logic [31:0] scaled_norm;
  logic        zero_diagonal, saturated;
  int          fail_count, pending_norms, norms_seen;
  int          items_sent, burst_left;
  bit          stall_mode;

  sparse_scaled_row_sum_norm uut (.*);

  sparse_scaled_row_sum_norm_chk checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stall the result side on its own pattern: long free runs, then heavy stalls.
  always @(posedge clk) begin
    if (rst) begin
      stall_mode   <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      result_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Hold one item until accepted; open random gaps between bursts.
  task automatic send_item(input logic [31:0] v, input logic [9:0] c,
                           input bit rl, input bit ml);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    item_valid   <= 1;
    entry_value  <= v;
    column_index <= c;
    row_last     <= rl;
    matrix_last  <= ml;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 3);
      4: return -$urandom_range(1, 32'h4_0000);
      default: return $urandom_range(1, 32'h4_0000);
    endcase
  endfunction

  // Send one matrix: n rows, diagonal first, up to max_off more entries; noisy adds stray columns, open last rows.
  task automatic send_matrix(input int n, input int max_off, input bit noisy);
    int k;
    logic [9:0] c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, max_off);
      for (int j = 0; j <= k; j++) begin
        c = (j == 0) ? 10'(i) : 10'($urandom_range(0, n - 1));
        if (noisy && $urandom_range(0, 9) == 0) c = 10'($urandom);
        send_item(j == 0 ? ($urandom_range(0, 15) == 0 ? 32'h0 : rand_value())
                         : rand_value(), c,
                  j == k && !(noisy && i == n - 1 && $urandom_range(0, 1)),
                  i == n - 1 && j == k);
      end
    end
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending_norms != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1; item_valid = 0; entry_value = 0; column_index = 0;
    row_last = 0; matrix_last = 0;
    items_sent = 0; burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // One-entry matrices at the extremes of the value field
    send_item(32'h0001_0000, 10'd0, 1'b1, 1'b1);
    send_item(32'h0000_0000, 10'd0, 1'b1, 1'b1);
    send_item(32'h0000_0001, 10'd0, 1'b1, 1'b1);
    send_item(32'h8000_0000, 10'd0, 1'b1, 1'b1);
    send_item(32'h7FFF_FFFF, 10'h3FF, 1'b1, 1'b1);
    // Open row closed by matrix end, column beyond the row count
    send_item(32'h0004_0000, 10'd0, 1'b0, 1'b0);
    send_item(32'hFFFF_0000, 10'h3FF, 1'b0, 1'b1);
    // Tiny diagonals with large off-diagonals: saturating sum
    send_item(32'h0000_0002, 10'd0, 1'b0, 1'b0);
    send_item(32'h7FFF_FFFF, 10'd1, 1'b1, 1'b0);
    send_item(32'h0000_0002, 10'd1, 1'b0, 1'b0);
    send_item(32'h8000_0001, 10'd0, 1'b1, 1'b1);
    // Wait for every result before going on
    drain();
    while (items_sent < 650) send_matrix($urandom_range(1, 12), 4, $urandom_range(0, 4) == 0);
    drain();
    // Past the row limit
    send_matrix(1030, 0, 0);
    drain();
    repeat (20000) @(posedge clk);
    $display("Run: %0d items, %0d norms checked, incl. zero diagonals, saturation, row limit.",
             items_sent, norms_seen);
    if (fail_count == 0) $display("PASS sparse_scaled_row_sum_norm");
    else $display("FAIL sparse_scaled_row_sum_norm");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL sparse_scaled_row_sum_norm");
    $finish;
  end
endmodule

@@ files.f @@
rtl/ssrsn_pkg.sv
rtl/ssrsn_front.sv
rtl/ssrsn_queue.sv
rtl/ssrsn_root.sv
rtl/ssrsn_back.sv
rtl/sparse_scaled_row_sum_norm.sv
bench/sparse_scaled_row_sum_norm_chk.sv
bench/sparse_scaled_row_sum_norm_tb.sv
